/* hw/rtl/sts_pkg.sv */
package sts_pkg;

  // Channel store depth and its address width.
  localparam int CHANNELS = 60;
  localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed field widths.
  localparam int CH_W      = 6;
  localparam int SMP_W     = 32;
  localparam int FRM_W     = 17;
  localparam int CNT_W     = 17;
  localparam int LAST_W    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int KIND_W    = 3;
  localparam int WIDX_W    = 2;
  localparam int WORD_W    = 32;
  localparam int OP_W      = 33;

  // The stimulation words always cover sixty channel slots.
  localparam int SLOTS        = 60;
  localparam int EN_BITS      = 30;
  localparam int ROUTE_CH     = 15;
  localparam int TRIG_SEG_BIT = 16;
  localparam int RES_IDX_W    = 4;

  localparam logic [RES_IDX_W-1:0] RES_ROUTE_FIRST = 4'd2;
  localparam logic [RES_IDX_W-1:0] RES_TRIGGER     = 4'd10;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Register reset values.
  localparam logic signed [SMP_W-1:0] THRESH_RST = 32'sd0;
  localparam logic [FRM_W-1:0]        DEAD_RST   = 17'd50;
  localparam logic [FRM_W-1:0]        WINDOW_RST = 17'd5000;
  localparam logic [FRM_W-1:0]        CYCLE_RST  = 17'd100000;
  localparam logic [FRM_W-1:0]        LEDOFF_RST = 17'd50000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_DEAD      = 3'd1,
    CFG_WINDOW    = 3'd2,
    CFG_CYCLE     = 3'd3,
    CFG_LED_OFF   = 3'd4
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENABLE  = 3'd0,
    KIND_DAC     = 3'd1,
    KIND_ECFG    = 3'd2,
    KIND_TRIGGER = 3'd3,
    KIND_LED     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP_THR,
    ST_CMP_DEAD,
    ST_WRITE,
    ST_FRAME,
    ST_EMIT,
    ST_ADVANCE
  } state_e;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_LED_ON,
    MODE_ANALYSIS,
    MODE_LED_OFF
  } mode_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] threshold;
    logic [FRM_W-1:0]        dead;
    logic [FRM_W-1:0]        window;
    logic [FRM_W-1:0]        cycle;
    logic [FRM_W-1:0]        led_off;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic signed [LAST_W-1:0] last;
  } rec_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              clear;
    logic [ADDR_W-1:0] addr;
    rec_t              wdata;
  } mem_req_t;

  typedef struct packed {
    rec_t rec;
    logic valid;
  } mem_rsp_t;

  typedef struct packed {
    kind_e             kind;
    logic [WIDX_W-1:0] idx;
    logic [WORD_W-1:0] value;
    logic              last;
  } res_t;

  // One word of the analysis burst: two enable words, then DAC and
  // electrode configuration words interleaved, then the trigger.
  function automatic res_t analysis_word(input logic [SLOTS-1:0]     act,
                                         input logic [RES_IDX_W-1:0] r,
                                         input logic                 seg);
    res_t                  res;
    logic [RES_IDX_W-1:0]  k;
    logic [WIDX_W-1:0]     w;
    logic [ROUTE_CH-1:0]   grp;
    res   = res_t'('0);
    k     = r - RES_ROUTE_FIRST;
    w     = k[2:1];
    grp   = act[w*ROUTE_CH +: ROUTE_CH];
    if (r < RES_ROUTE_FIRST) begin
      res.kind  = KIND_ENABLE;
      res.idx   = r[WIDX_W-1:0];
      res.value = {{(WORD_W-EN_BITS){1'b0}}, act[r[0]*EN_BITS +: EN_BITS]};
    end else if (r < RES_TRIGGER) begin
      res.idx = w;
      if (!k[0]) begin
        res.kind = KIND_DAC;
        for (int j = 0; j < ROUTE_CH; j++) begin
          res.value[2*j] = grp[j];
        end
      end else begin
        res.kind = KIND_ECFG;
        for (int j = 0; j < ROUTE_CH; j++) begin
          res.value[2*j +: 2] = {2{~grp[j]}};
        end
      end
    end else begin
      res.kind                = KIND_TRIGGER;
      res.value[TRIG_SEG_BIT] = seg;
      res.last                = 1'b1;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/sts_in_if.sv */
interface sts_in_if;
  logic                               valid;
  logic                               ready;
  logic [sts_pkg::CH_W-1:0]           channel;
  logic signed [sts_pkg::SMP_W-1:0]   sample;
  logic                               frame_end;

  modport source (output valid, output channel, output sample, output frame_end,
                  input ready);
  modport sink   (input valid, input channel, input sample, input frame_end,
                  output ready);
endinterface

/* hw/rtl/sts_out_if.sv */
interface sts_out_if;
  logic                           valid;
  logic                           ready;
  logic [sts_pkg::KIND_W-1:0]     kind;
  logic [sts_pkg::WIDX_W-1:0]     word_index;
  logic [sts_pkg::WORD_W-1:0]     word_value;
  logic                           last_result;

  modport source (output valid, output kind, output word_index, output word_value,
                  output last_result, input ready);
  modport sink   (input valid, input kind, input word_index, input word_value,
                  input last_result, output ready);
endinterface

/* hw/rtl/sts_alu.sv */
module sts_alu (
  input  logic signed [sts_pkg::OP_W-1:0] a_i,
  input  logic signed [sts_pkg::OP_W-1:0] b_i,
  output logic                            lt_o
);
  import sts_pkg::*;

  logic signed [OP_W:0] diff;

  // One guard bit keeps the sign of the difference exact.
  assign diff = {a_i[OP_W-1], a_i} - {b_i[OP_W-1], b_i};
  assign lt_o = diff[OP_W];

endmodule

/* hw/rtl/sts_chan_mem.sv */
module sts_chan_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sts_pkg::mem_req_t              req_i,
  output sts_pkg::mem_rsp_t              rsp_o,
  output logic [sts_pkg::SLOTS-1:0]      active_o
);
  import sts_pkg::*;

  rec_t                mem_q [CHANNELS];
  rec_t                rec_q;
  logic                rd_valid_q;
  logic [CHANNELS-1:0] valid_q;
  logic [SLOTS-1:0]    active_q;
  logic [SLOTS-1:0]    active_d;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rec_q <= mem_q[req_i.addr];
    end
  end

  // A channel counts as active once it has been stamped since the last clear.
  always_comb begin
    active_d = active_q;
    for (int c = 0; c < SLOTS; c++) begin
      if (req_i.wr && (int'(req_i.addr) == c)) begin
        active_d[c] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      active_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q  <= '0;
        active_q <= '0;
      end else if (req_i.wr) begin
        valid_q[req_i.addr] <= 1'b1;
        active_q            <= active_d;
      end
      if (req_i.rd) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rsp_o.rec   = rec_q;
  assign rsp_o.valid = rd_valid_q;
  assign active_o    = active_q;

  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.rd |-> (!req_i.wr && !req_i.clear))
    else $error("channel store read collides with a write or clear");

endmodule

/* hw/rtl/sts_seq.sv */
module sts_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sts_pkg::cfg_t                    cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sts_pkg::CH_W-1:0]         in_channel_i,
  input  logic signed [sts_pkg::SMP_W-1:0] in_sample_i,
  input  logic                             in_frame_end_i,
  input  logic                             out_free_i,
  output logic                             res_load_o,
  output sts_pkg::res_t                    res_o,
  output sts_pkg::mem_req_t                mem_req_o,
  input  sts_pkg::mem_rsp_t                mem_rsp_i,
  input  logic [sts_pkg::SLOTS-1:0]        active_i,
  output logic signed [sts_pkg::OP_W-1:0]  alu_a_o,
  output logic signed [sts_pkg::OP_W-1:0]  alu_b_o,
  input  logic                             alu_lt_i
);
  import sts_pkg::*;

  state_e                  state_q, state_d;
  mode_e                   mode_q, mode_d;
  logic [CH_W-1:0]         ch_q, ch_d;
  logic signed [SMP_W-1:0] smp_q, smp_d;
  logic                    fend_q, fend_d;
  logic                    hit_q, hit_d;
  logic [FRM_W-1:0]        fc_q, fc_d;
  logic                    seg_q, seg_d;
  logic [FRM_W-1:0]        dead_clr_q, dead_clr_d;
  logic [RES_IDX_W-1:0]    r_q, r_d;

  logic                     accept;
  logic                     collect;
  logic signed [LAST_W-1:0] last_eff;
  logic [CNT_W-1:0]         count_eff;
  logic signed [LAST_W:0]   bound_sum;

  assign accept  = in_valid_i && in_ready_o;
  assign collect = (fc_q != '0) && (fc_q < cfg_i.window)
                   && (in_channel_i < CH_W'(CHANNELS));

  // An entry not written since the last clear holds the values of the clear.
  assign last_eff  = mem_rsp_i.valid ? mem_rsp_i.rec.last
                                     : -$signed({1'b0, dead_clr_q});
  assign count_eff = mem_rsp_i.valid ? mem_rsp_i.rec.count : '0;
  // frame - last > dead is tested as dead + last < frame.
  assign bound_sum = $signed({2'b00, cfg_i.dead}) + $signed({last_eff[LAST_W-1], last_eff});

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    ch_d       = ch_q;
    smp_d      = smp_q;
    fend_d     = fend_q;
    hit_d      = hit_q;
    fc_d       = fc_q;
    seg_d      = seg_q;
    dead_clr_d = dead_clr_q;
    r_d        = r_q;
    in_ready_o = 1'b0;
    res_load_o = 1'b0;
    res_o      = res_t'('0);
    mem_req_o  = mem_req_t'('0);
    mem_req_o.addr = ch_q[ADDR_W-1:0];
    alu_a_o    = {{(OP_W-SMP_W){smp_q[SMP_W-1]}}, smp_q};
    alu_b_o    = {{(OP_W-SMP_W){cfg_i.threshold[SMP_W-1]}}, cfg_i.threshold};

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          ch_d   = in_channel_i;
          smp_d  = in_sample_i;
          fend_d = in_frame_end_i;
          if (collect) begin
            mem_req_o.rd   = 1'b1;
            mem_req_o.addr = in_channel_i[ADDR_W-1:0];
            state_d        = ST_CMP_THR;
          end else if (in_frame_end_i) begin
            state_d = ST_FRAME;
          end
        end
      end
      ST_CMP_THR: begin
        hit_d   = alu_lt_i;
        state_d = ST_CMP_DEAD;
      end
      ST_CMP_DEAD: begin
        alu_a_o = {{(OP_W-LAST_W-1){bound_sum[LAST_W]}}, bound_sum};
        alu_b_o = {{(OP_W-FRM_W){1'b0}}, fc_q};
        if (hit_q && alu_lt_i) begin
          state_d = ST_WRITE;
        end else begin
          state_d = fend_q ? ST_FRAME : ST_IDLE;
        end
      end
      ST_WRITE: begin
        mem_req_o.wr          = 1'b1;
        mem_req_o.wdata.count = (count_eff == COUNT_MAX) ? count_eff : count_eff + 1'b1;
        mem_req_o.wdata.last  = $signed({1'b0, fc_q});
        state_d               = fend_q ? ST_FRAME : ST_IDLE;
      end
      ST_FRAME: begin
        r_d = '0;
        priority if (fc_q == '0) begin
          mem_req_o.clear = 1'b1;
          dead_clr_d      = cfg_i.dead;
          mode_d          = MODE_LED_ON;
          state_d         = ST_EMIT;
        end else if (fc_q == cfg_i.window) begin
          mode_d  = MODE_ANALYSIS;
          state_d = ST_EMIT;
        end else if (fc_q == cfg_i.led_off) begin
          mode_d  = MODE_LED_OFF;
          state_d = ST_EMIT;
        end else begin
          mode_d  = MODE_NONE;
          state_d = ST_ADVANCE;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          unique case (mode_q)
            MODE_ANALYSIS: begin
              res_o = analysis_word(active_i, r_q, seg_q);
              r_d   = r_q + 1'b1;
              if (r_q == RES_TRIGGER) begin
                state_d = ST_ADVANCE;
              end
            end
            MODE_LED_ON: begin
              res_o.kind  = KIND_LED;
              res_o.value = WORD_W'(1);
              res_o.last  = 1'b1;
              state_d     = ST_ADVANCE;
            end
            MODE_LED_OFF: begin
              res_o.kind = KIND_LED;
              res_o.last = 1'b1;
              state_d    = ST_ADVANCE;
            end
            MODE_NONE: begin
              res_load_o = 1'b0;
              state_d    = ST_ADVANCE;
            end
          endcase
        end
      end
      ST_ADVANCE: begin
        fc_d = (fc_q >= cfg_i.cycle) ? '0 : fc_q + 1'b1;
        if (mode_q == MODE_ANALYSIS) begin
          seg_d = ~seg_q;
        end
        mode_d  = MODE_NONE;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_NONE;
      fc_q       <= '0;
      seg_q      <= 1'b0;
      dead_clr_q <= DEAD_RST;
      r_q        <= '0;
      fend_q     <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      fc_q       <= fc_d;
      seg_q      <= seg_d;
      dead_clr_q <= dead_clr_d;
      r_q        <= r_d;
      fend_q     <= fend_d;
      hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q  <= ch_d;
    smp_q <= smp_d;
  end

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr |-> (ch_q < CH_W'(CHANNELS)))
    else $error("channel store written for a channel out of range");

  a_emit_on_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> fend_q)
    else $error("result word issued for a sample without frame end");

  a_frame_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADVANCE) |=> ((fc_q == '0) || (fc_q == $past(fc_q) + 1'b1)))
    else $error("frame counter moved other than by one or to zero");

  a_seg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((state_q == ST_ADVANCE) && (mode_q == MODE_ANALYSIS)) |=> $stable(seg_q))
    else $error("segment toggled outside an analysis frame");

endmodule

/* hw/rtl/spike_threshold_stim_selector.sv */
// Threshold spike detector with a refractory period per channel. Each sample is
// checked against the threshold and its channel's last crossing by one shared
// comparator used twice, with a read-modify-write of the single-port channel
// store: a sample in a collection frame goes through the threshold compare and
// the dead-time compare, and through a write when it counts as a crossing. A
// frame end then issues any result words (one LED word, or 11 for the analysis
// burst), waiting while the output word is not taken. Frame 0 clears the
// channel store at once through per-channel valid bits, so no clearing pass
// is needed. The next sample is taken while the last result still waits.
module spike_threshold_stim_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sts_in_if.sink                           in_i,
  sts_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [sts_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sts_pkg::CFG_W-1:0]        cfg_data_i
);
  import sts_pkg::*;

  cfg_t                  cfg_q;
  mem_req_t              mem_req;
  mem_rsp_t              mem_rsp;
  logic [SLOTS-1:0]      active;
  logic signed [OP_W-1:0] alu_a;
  logic signed [OP_W-1:0] alu_b;
  logic                  alu_lt;
  logic                  res_load;
  res_t                  res;
  res_t                  out_res_q;
  logic                  out_valid_q;
  logic                  out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESH_RST;
      cfg_q.dead      <= DEAD_RST;
      cfg_q.window    <= WINDOW_RST;
      cfg_q.cycle     <= CYCLE_RST;
      cfg_q.led_off   <= LEDOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD: cfg_q.threshold <= $signed(cfg_data_i);
        CFG_DEAD:      cfg_q.dead      <= cfg_data_i[FRM_W-1:0];
        CFG_WINDOW:    cfg_q.window    <= cfg_data_i[FRM_W-1:0];
        CFG_CYCLE:     cfg_q.cycle     <= cfg_data_i[FRM_W-1:0];
        CFG_LED_OFF:   cfg_q.led_off   <= cfg_data_i[FRM_W-1:0];
        default: ;
      endcase
    end
  end

  sts_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .in_channel_i   (in_i.channel),
    .in_sample_i    (in_i.sample),
    .in_frame_end_i (in_i.frame_end),
    .out_free_i     (out_free),
    .res_load_o     (res_load),
    .res_o          (res),
    .mem_req_o      (mem_req),
    .mem_rsp_i      (mem_rsp),
    .active_i       (active),
    .alu_a_o        (alu_a),
    .alu_b_o        (alu_b),
    .alu_lt_i       (alu_lt)
  );

  sts_chan_mem u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rsp_o    (mem_rsp),
    .active_o (active)
  );

  sts_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .lt_o (alu_lt)
  );

  // The output register frees up in the same cycle its word is taken.
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_res_q.kind;
  assign out_o.word_index  = out_res_q.idx;
  assign out_o.word_value  = out_res_q.value;
  assign out_o.last_result = out_res_q.last;

endmodule
